[rtl/sha1md_pkg.sv]
package sha1md_pkg;

   localparam int WordWidth   = 32;
   localparam int BufferDepth = 16;
   localparam int RoundCount  = 80;
   localparam int DigestWords = 5;

   typedef logic [WordWidth-1:0]                  word_type;
   typedef logic [DigestWords-1:0][WordWidth-1:0] digest_type;
   typedef logic [2:0]                            nbytes_type;
   typedef logic [2:0]                            windex_type;
   typedef logic [3:0]                            fill_type;
   typedef logic [6:0]                            round_type;
   typedef logic [63:0]                           length_type;

   // Round groups of twenty rounds each; they pick the mixing function and constant.
   typedef enum logic [1:0] {
      GRP_CHOOSE   = 2'd0,
      GRP_PARITY_A = 2'd1,
      GRP_MAJORITY = 2'd2,
      GRP_PARITY_B = 2'd3
   } group_type;

   typedef struct packed {
      logic      load;
      logic      step;
      logic      fold;
      logic      init;
      group_type group;
   } round_ctrl_type;

   // Element 0 is H0, the most significant digest word.
   localparam digest_type InitHash = {
      32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
   };

   localparam word_type   PadMarker  = 32'h8000_0000;
   localparam nbytes_type FullBytes  = 3'd4;
   localparam fill_type   LengthSlot = 4'd14;
   localparam fill_type   LastSlot   = 4'd15;
   localparam round_type  LastRound  = 7'(RoundCount - 1);
   localparam windex_type LastIndex  = 3'(DigestWords - 1);

endpackage

[rtl/sha1md_req_if.sv]
interface sha1md_req_if;
   logic                    valid;
   logic                    ready;
   sha1md_pkg::word_type    data_word;
   sha1md_pkg::nbytes_type  valid_bytes;
   logic                    last;

   modport source (output valid, data_word, valid_bytes, last, input ready);
   modport sink (input valid, data_word, valid_bytes, last, output ready);
endinterface

[rtl/sha1md_rsp_if.sv]
interface sha1md_rsp_if;
   logic                    valid;
   logic                    ready;
   sha1md_pkg::word_type    digest_word;
   sha1md_pkg::windex_type  word_index;
   logic                    last_word;

   modport source (output valid, digest_word, word_index, last_word, input ready);
   modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

[rtl/sha1_message_digest_unit.sv]
// SHA-1 digest unit. A message arrives as big-endian 32-bit words, one word per
// request, and the request marked last may carry 0 to 4 valid leading bytes.
// After the last request the unit pads the message, appends the 64-bit bit
// length and returns the 160-bit digest as five response words, H0 first, the
// fifth one flagged with last_word; it then starts over for a new message.
// A request that does not complete a 512-bit block is taken at once. The
// request that completes a block starts a compression (80 rounds through the
// single round adder, then a fold step that adds the working words into the
// chain value), and no request is taken meanwhile.
// After the last request the padding words are written one per cycle up to the
// end of the block, followed by one or two compressions; the digest then
// appears, and each response word waits on rsp_chan.ready.
module sha1_message_digest_unit (
   input logic          clock,
   input logic          reset,
   sha1md_req_if.sink   req_chan,
   sha1md_rsp_if.source rsp_chan
);
   import sha1md_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_ROUND = 5'b00010,
      ST_FOLD  = 5'b00100,
      ST_PAD   = 5'b01000,
      ST_SEND  = 5'b10000
   } state_type;

   state_type  state_ff, state_in;
   fill_type   fill_ff, fill_in;
   length_type bit_length_ff, bit_length_in;
   round_type  round_ff, round_in;
   windex_type index_ff, index_in;
   logic       finishing_ff, finishing_in;   // message end seen, padding under way
   logic       marker_ff, marker_in;         // marker word still to be written
   logic       length_lo_ff, length_lo_in;   // high length word written

   logic           req_fire;
   logic           rsp_fire;
   nbytes_type     nbytes;
   word_type       merged;
   logic           push;
   word_type       push_word;
   logic           block_full;
   word_type       sched_word;
   digest_type     chain;
   round_ctrl_type ctrl;

   assign req_fire = req_chan.valid && req_chan.ready;
   assign rsp_fire = rsp_chan.valid && rsp_chan.ready;

   // Byte counts above four on the last request count as a full word.
   assign nbytes = (req_chan.valid_bytes > FullBytes) ? FullBytes : req_chan.valid_bytes;

   // The valid leading bytes are kept and the marker byte follows them directly.
   always_comb begin
      case (nbytes)
         3'd0:    merged = PadMarker;
         3'd1:    merged = {req_chan.data_word[31:24], 8'h80, 16'h0000};
         3'd2:    merged = {req_chan.data_word[31:16], 8'h80, 8'h00};
         3'd3:    merged = {req_chan.data_word[31:8], 8'h80};
         default: merged = req_chan.data_word;
      endcase
   end

   // One word enters the block buffer per cycle, either from a request or from
   // the padding sequence, and none while the rounds run or the digest is returned.
   always_comb begin
      push      = 1'b0;
      push_word = '0;
      if (state_ff == ST_IDLE && req_fire) begin
         push      = 1'b1;
         push_word = req_chan.last ? merged : req_chan.data_word;
      end else if (state_ff == ST_PAD) begin
         push = 1'b1;
         if (marker_ff) begin
            push_word = PadMarker;
         end else if (length_lo_ff) begin
            push_word = bit_length_ff[31:0];
         end else if (fill_ff == LengthSlot) begin
            push_word = bit_length_ff[63:32];
         end
      end
   end

   assign block_full = push && (fill_ff == LastSlot);

   always_comb begin
      state_in      = state_ff;
      fill_in       = push ? fill_ff + 4'd1 : fill_ff;
      bit_length_in = bit_length_ff;
      round_in      = round_ff;
      index_in      = index_ff;
      finishing_in  = finishing_ff;
      marker_in     = marker_ff;
      length_lo_in  = length_lo_ff;
      ctrl          = '{load: block_full, step: 1'b0, fold: 1'b0, init: 1'b0,
                        group: GRP_CHOOSE};

      if (round_ff < 7'd20) begin
         ctrl.group = GRP_CHOOSE;
      end else if (round_ff < 7'd40) begin
         ctrl.group = GRP_PARITY_A;
      end else if (round_ff < 7'd60) begin
         ctrl.group = GRP_MAJORITY;
      end else begin
         ctrl.group = GRP_PARITY_B;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_chan.last) begin
                  bit_length_in = bit_length_ff + length_type'({nbytes, 3'b000});
                  finishing_in  = 1'b1;
                  marker_in     = (nbytes == FullBytes);
               end else begin
                  bit_length_in = bit_length_ff + length_type'(WordWidth);
               end
               if (block_full) begin
                  state_in = ST_ROUND;
               end else if (req_chan.last) begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            marker_in = 1'b0;
            if (!marker_ff && fill_ff == LengthSlot) begin
               length_lo_in = 1'b1;
            end
            if (block_full) begin
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            ctrl.step = 1'b1;
            if (round_ff == LastRound) begin
               round_in = '0;
               state_in = ST_FOLD;
            end else begin
               round_in = round_ff + 7'd1;
            end
         end
         ST_FOLD: begin
            ctrl.fold = 1'b1;
            if (length_lo_ff) begin
               state_in = ST_SEND;
            end else if (finishing_ff) begin
               state_in = ST_PAD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_SEND: begin
            if (rsp_fire) begin
               if (index_ff == LastIndex) begin
                  // Back to the initial state for the next message.
                  ctrl.init     = 1'b1;
                  index_in      = '0;
                  fill_in       = '0;
                  bit_length_in = '0;
                  finishing_in  = 1'b0;
                  marker_in     = 1'b0;
                  length_lo_in  = 1'b0;
                  state_in      = ST_IDLE;
               end else begin
                  index_in = index_ff + 3'd1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         fill_ff       <= '0;
         bit_length_ff <= '0;
         round_ff      <= '0;
         index_ff      <= '0;
         finishing_ff  <= 1'b0;
         marker_ff     <= 1'b0;
         length_lo_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         fill_ff       <= fill_in;
         bit_length_ff <= bit_length_in;
         round_ff      <= round_in;
         index_ff      <= index_in;
         finishing_ff  <= finishing_in;
         marker_ff     <= marker_in;
         length_lo_ff  <= length_lo_in;
      end
   end

   sha1md_sched u_sched (
      .clock      (clock),
      .push       (push),
      .push_word  (push_word),
      .step       (ctrl.step),
      .sched_word (sched_word)
   );

   sha1md_round u_round (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .sched_word (sched_word),
      .chain      (chain)
   );

   assign req_chan.ready       = (state_ff == ST_IDLE);
   assign rsp_chan.valid       = (state_ff == ST_SEND);
   assign rsp_chan.digest_word = chain[index_ff];
   assign rsp_chan.word_index  = index_ff;
   assign rsp_chan.last_word   = (index_ff == LastIndex);

`ifndef SYNTHESIS
   // Requests are never taken while the digest is being returned.
   assert property (@(posedge clock) disable iff (reset)
      !(req_chan.ready && rsp_chan.valid))
      else $error("request ready while a response is pending");

   // The round counter never passes the last round.
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_ROUND |-> round_ff <= LastRound)
      else $error("round counter out of range");

   // After the fifth digest word the unit is back in its initial state.
   assert property (@(posedge clock) disable iff (reset)
      rsp_fire && rsp_chan.last_word |=>
         state_ff == ST_IDLE && fill_ff == '0 && bit_length_ff == '0 && !finishing_ff)
      else $error("unit not cleared after the digest");
`endif

endmodule

[rtl/sha1md_sched.sv]
module sha1md_sched (
   input  logic                 clock,
   input  logic                 push,
   input  sha1md_pkg::word_type push_word,
   input  logic                 step,
   output sha1md_pkg::word_type sched_word
);
   import sha1md_pkg::*;

   // Sixteen-word window: entry 0 is the oldest word, which is the
   // schedule word of the current round.
   word_type window_ff [BufferDepth];
   word_type window_in [BufferDepth];
   word_type mix;
   word_type expanded;

   assign mix      = window_ff[13] ^ window_ff[8] ^ window_ff[2] ^ window_ff[0];
   assign expanded = {mix[30:0], mix[31]};

   always_comb begin
      window_in = window_ff;
      if (push || step) begin
         for (int i = 0; i < BufferDepth - 1; i++) begin
            window_in[i] = window_ff[i + 1];
         end
         window_in[BufferDepth - 1] = push ? push_word : expanded;
      end
   end

   always_ff @(posedge clock) begin
      window_ff <= window_in;
   end

   assign sched_word = window_ff[0];

endmodule

[rtl/sha1md_round.sv]
module sha1md_round (
   input  logic                       clock,
   input  logic                       reset,
   input  sha1md_pkg::round_ctrl_type ctrl,
   input  sha1md_pkg::word_type       sched_word,
   output sha1md_pkg::digest_type     chain
);
   import sha1md_pkg::*;

   digest_type chain_ff, chain_in;
   digest_type work_ff, work_in;
   word_type   mix_f;
   word_type   round_k;
   word_type   temp;

   always_comb begin
      case (ctrl.group)
         GRP_CHOOSE: begin
            mix_f   = (work_ff[1] & work_ff[2]) ^ (~work_ff[1] & work_ff[3]);
            round_k = 32'h5A827999;
         end
         GRP_PARITY_A: begin
            mix_f   = work_ff[1] ^ work_ff[2] ^ work_ff[3];
            round_k = 32'h6ED9EBA1;
         end
         GRP_MAJORITY: begin
            mix_f   = (work_ff[1] & work_ff[2]) ^ (work_ff[1] & work_ff[3])
                    ^ (work_ff[2] & work_ff[3]);
            round_k = 32'h8F1BBCDC;
         end
         default: begin
            mix_f   = work_ff[1] ^ work_ff[2] ^ work_ff[3];
            round_k = 32'hCA62C1D6;
         end
      endcase
   end

   assign temp = {work_ff[0][26:0], work_ff[0][31:27]} + mix_f + work_ff[4]
               + round_k + sched_word;

   always_comb begin
      work_in = work_ff;
      if (ctrl.load) begin
         work_in = chain_ff;
      end else if (ctrl.step) begin
         work_in[0] = temp;
         work_in[1] = work_ff[0];
         work_in[2] = {work_ff[1][1:0], work_ff[1][31:2]};
         work_in[3] = work_ff[2];
         work_in[4] = work_ff[3];
      end
   end

   always_comb begin
      chain_in = chain_ff;
      if (ctrl.init) begin
         chain_in = InitHash;
      end else if (ctrl.fold) begin
         for (int i = 0; i < DigestWords; i++) begin
            chain_in[i] = chain_ff[i] + work_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chain_ff <= InitHash;
      end else begin
         chain_ff <= chain_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
   end

   assign chain = chain_ff;

endmodule
